[design/psg_pkg.sv]
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types, envelope segment codes and constant tables for the sound
// generator.
// ----------------------------------------------------------------------------
package psg_pkg;

  typedef logic [2:0] seg_op_t;

  localparam seg_op_t SEG_UP   = 3'd0;
  localparam seg_op_t SEG_DOWN = 3'd1;
  localparam seg_op_t SEG_ZERO = 3'd2;
  localparam seg_op_t SEG_ONE  = 3'd3;
  localparam seg_op_t SEG_REPT = 3'd4;
  localparam seg_op_t SEG_KEEP = 3'd5;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam int unsigned PRESCALE_NOMINAL = 2;
  localparam logic [31:0] TICK_STEP = 32'd1000;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // segment walk of each envelope shape
  function automatic seg_op_t shape_op(input logic [3:0] shape, input logic [1:0] seg);
    seg_op_t row [4];
    row[0] = SEG_KEEP;
    row[1] = SEG_KEEP;
    row[2] = SEG_KEEP;
    row[3] = SEG_KEEP;
    unique case (shape)
      4'd8: begin
        row[0] = SEG_DOWN; row[1] = SEG_REPT;
      end
      4'd10: begin
        row[0] = SEG_DOWN; row[1] = SEG_UP; row[2] = SEG_REPT;
      end
      4'd11: begin
        row[0] = SEG_DOWN; row[1] = SEG_ONE;
      end
      4'd12: begin
        row[0] = SEG_UP; row[1] = SEG_REPT;
      end
      4'd13: begin
        row[0] = SEG_UP; row[1] = SEG_ONE;
      end
      4'd14: begin
        row[0] = SEG_UP; row[1] = SEG_DOWN; row[2] = SEG_REPT;
      end
      4'd4, 4'd5, 4'd6, 4'd7, 4'd15: begin
        row[0] = SEG_UP; row[1] = SEG_ZERO;
      end
      default: begin
        row[0] = SEG_DOWN; row[1] = SEG_ZERO;
      end
    endcase
    return row[seg];
  endfunction

  // logarithmic volume weights, full scale 65535
  function automatic logic [15:0] level_weight(input logic [3:0] v);
    logic [15:0] w;
    unique case (v)
      4'd0:  w = 16'd0;
      4'd1:  w = 16'd511;
      4'd2:  w = 16'd724;
      4'd3:  w = 16'd1023;
      4'd4:  w = 16'd1448;
      4'd5:  w = 16'd2047;
      4'd6:  w = 16'd2896;
      4'd7:  w = 16'd4095;
      4'd8:  w = 16'd5792;
      4'd9:  w = 16'd8191;
      4'd10: w = 16'd11585;
      4'd11: w = 16'd16383;
      4'd12: w = 16'd23170;
      4'd13: w = 16'd32767;
      4'd14: w = 16'd46340;
      default: w = 16'd65535;
    endcase
    return w;
  endfunction

endpackage

[design/psg_three_voice_sample_generator_top.sv]
// Read: the register is captured at accept and returned from the final step; cmd 3 is dropped in its accept cycle.
// Tick: the voices, the envelope and the noise are stepped in turn, all through the shared adder.
// Write: up to five double divisions on the one bit per cycle divider.
// One item at a time.
// Reset is synchronous: registers clear, noise period loads its value for
// all-zero registers, no clearing pass.
// ----------------------------------------------------------------------------
// psg_three_voice_sample_generator_top
// Three tone voices, noise and envelope, one sample per tick word.
// ----------------------------------------------------------------------------
module psg_three_voice_sample_generator_top #(
  parameter int SAMPLE_RATE    = 44100,
  parameter int CHIP_CLOCK_HZ  = 1228800,
  parameter int PRESCALE_BASE  = 2,
  parameter int ENVELOPE_TOP   = 255,
  parameter int PEAK_AMPLITUDE = 8192
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [3:0]         reg_index,
  input  logic [7:0]         write_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] sample,
  output logic [7:0]         read_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_data
);

  localparam longint F_TONE  = ((longint'(CHIP_CLOCK_HZ) * 1000 / 16)
                                * psg_pkg::PRESCALE_NOMINAL) / PRESCALE_BASE;
  localparam longint F_ENV   = ((longint'(CHIP_CLOCK_HZ) * 1000 / 256)
                                * psg_pkg::PRESCALE_NOMINAL) / PRESCALE_BASE;
  localparam longint F_NOISE = longint'(CHIP_CLOCK_HZ) * 1000 / 16;
  localparam longint NUM     = longint'(SAMPLE_RATE) * 1000000;
  localparam longint F_MAX   = (F_TONE > F_NOISE) ? F_TONE : F_NOISE;
  localparam int N_W = $clog2(NUM + 1);
  localparam int D_W = $clog2(F_MAX + 1);
  localparam logic [31:0] NOISE_RESET = 32'(NUM / F_NOISE);
  localparam logic [31:0] ENV_STEP    = 32'(longint'(ENVELOPE_TOP) * 1000);
  localparam logic [15:0] ENV_TOP     = 16'(ENVELOPE_TOP);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PREP   = 4'd1;
  localparam logic [3:0] S_DIV1   = 4'd2;
  localparam logic [3:0] S_DIV2   = 4'd3;
  localparam logic [3:0] S_T_ADD  = 4'd4;
  localparam logic [3:0] S_T_CMP  = 4'd5;
  localparam logic [3:0] S_T_MIXT = 4'd6;
  localparam logic [3:0] S_T_MIXN = 4'd7;
  localparam logic [3:0] S_E_ADD  = 4'd8;
  localparam logic [3:0] S_E_CMP  = 4'd9;
  localparam logic [3:0] S_E_ELAP = 4'd10;
  localparam logic [3:0] S_E_SEG  = 4'd11;
  localparam logic [3:0] S_N_ADD  = 4'd12;
  localparam logic [3:0] S_N_LOOP = 4'd13;
  localparam logic [3:0] S_FIN    = 4'd14;

  localparam logic [2:0] JOB_ENV   = 3'd3;
  localparam logic [2:0] JOB_NOISE = 3'd4;

  logic [3:0]  state;
  logic [2:0]  job;
  logic [1:0]  ch;
  logic [2:0]  mute_mask;
  logic [7:0]  regs [16];
  logic [31:0] tone_half [3];
  logic [31:0] tone_bal [3];
  logic [2:0]  tone_phase;
  logic [31:0] env_period;
  logic [31:0] env_bal;
  logic [31:0] env_elapsed;
  logic [15:0] env_level;
  logic [1:0]  env_seg;
  logic [31:0] noise_period;
  logic [31:0] noise_bal;
  logic [23:0] noise_shift;
  logic signed [15:0] acc;
  logic [7:0]  rd_hold;

  logic in_acc;
  assign in_stall = state != S_IDLE;
  assign in_acc   = in_valid && !in_stall;

  // shared adder, subtractor and compare
  logic [31:0] alu_a, alu_b, alu_res;
  logic        alu_sub, alu_ge;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state)
      S_T_ADD: begin
        alu_a = tone_bal[ch]; alu_b = psg_pkg::TICK_STEP;
      end
      S_T_CMP: begin
        alu_a = tone_bal[ch]; alu_b = tone_half[ch]; alu_sub = 1'b1;
      end
      S_E_ADD: begin
        alu_a = env_bal; alu_b = ENV_STEP;
      end
      S_E_CMP: begin
        alu_a = env_bal; alu_b = env_period; alu_sub = 1'b1;
      end
      S_E_ELAP: begin
        alu_a = env_elapsed; alu_b = psg_pkg::TICK_STEP;
      end
      S_E_SEG: begin
        alu_a = env_elapsed; alu_b = env_period; alu_sub = 1'b1;
      end
      S_N_ADD: begin
        alu_a = noise_bal; alu_b = psg_pkg::TICK_STEP;
      end
      S_N_LOOP: begin
        alu_a = noise_bal; alu_b = noise_period; alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_res = alu_sub ? alu_a - alu_b : alu_a + alu_b;
  assign alu_ge  = alu_a >= alu_b;

  // volume lookup
  logic [14:0] amp_tab [16];
  logic [14:0] env_ge;

  for (genvar i = 0; i < 16; i++) begin : g_amp
    localparam longint Amp = (longint'(PEAK_AMPLITUDE)
                              * longint'(psg_pkg::level_weight(4'(i)))) / 65535;
    assign amp_tab[i] = 15'(Amp);
  end

  // envelope index is level*16/top, found by threshold compares
  for (genvar k = 1; k < 16; k++) begin : g_env_th
    localparam longint Th = (longint'(k) * ENVELOPE_TOP + 15) / 16;
    assign env_ge[k-1] = {1'b0, env_level} >= 17'(Th);
  end

  logic [7:0]  vol_reg;
  logic [3:0]  vol_idx;
  logic [14:0] amp;
  logic        tone_on, muted, noise_on;

  always_comb begin
    unique case (ch)
      2'd1:    vol_reg = regs[9];
      2'd2:    vol_reg = regs[10];
      default: vol_reg = regs[8];
    endcase
  end

  assign vol_idx  = vol_reg[4] ? 4'($countones(env_ge)) : vol_reg[3:0];
  assign amp      = amp_tab[vol_idx];
  assign tone_on  = (tone_half[ch] != '0) && !regs[7][{1'b0, ch}];
  assign muted    = mute_mask[ch];
  assign noise_on = !regs[7][3'd3 + {1'b0, ch}] && (noise_period != '0) && !muted;

  logic        mix_neg;
  logic signed [17:0] mix_sum;
  logic signed [15:0] mix_sat;

  assign mix_neg = (state == S_T_MIXT) ? !tone_phase[ch] : noise_shift[0];
  assign mix_sum = 18'(acc) + (mix_neg ? -$signed({3'b000, amp}) : $signed({3'b000, amp}));

  always_comb begin
    priority if (mix_sum > 18'sd32767) begin
      mix_sat = 16'sd32767;
    end else if (mix_sum < -18'sd32767) begin
      mix_sat = -16'sd32767;
    end else begin
      mix_sat = mix_sum[15:0];
    end
  end

  // envelope segment walk
  psg_pkg::seg_op_t op_cur, op_inc, op_new, op_wr;
  logic [1:0] seg_inc, seg_new;

  assign op_cur  = psg_pkg::shape_op(regs[13][3:0], env_seg);
  assign seg_inc = env_seg + 2'd1;
  assign op_inc  = psg_pkg::shape_op(regs[13][3:0], seg_inc);
  assign seg_new = (op_inc == psg_pkg::SEG_REPT) ? 2'd0 : seg_inc;
  assign op_new  = psg_pkg::shape_op(regs[13][3:0], seg_new);
  assign op_wr   = psg_pkg::shape_op(write_data[3:0], 2'd0);

  logic [23:0] noise_next;
  assign noise_next = {noise_shift[0] ^ noise_shift[1] ^ noise_shift[2] ^ noise_shift[7],
                       noise_shift[23:1]};

  // period job setup
  logic           job_en;
  logic [15:0]    job_d;
  logic [N_W-1:0] job_f;

  always_comb begin
    unique case (job)
      3'd0: begin
        job_en = !regs[7][0]; job_d = {4'h0, regs[1][3:0], regs[0]};
        job_f = N_W'(F_TONE);
      end
      3'd1: begin
        job_en = !regs[7][1]; job_d = {4'h0, regs[3][3:0], regs[2]};
        job_f = N_W'(F_TONE);
      end
      3'd2: begin
        job_en = !regs[7][2]; job_d = {4'h0, regs[5][3:0], regs[4]};
        job_f = N_W'(F_TONE);
      end
      JOB_ENV: begin
        job_en = 1'b1; job_d = {regs[12], regs[11]};
        job_f = N_W'(F_ENV);
      end
      default: begin
        job_en = regs[7][5:3] != 3'b111; job_d = 16'(regs[6][4:0]) + 16'd1;
        job_f = N_W'(F_NOISE);
      end
    endcase
  end

  logic                div_start;
  logic [N_W-1:0]      div_dividend;
  logic [D_W-1:0]      div_divisor;
  psg_pkg::div_stat_t  div_stat;
  logic [N_W-1:0]      div_q;
  logic                q1_zero;
  logic [31:0]         period_val;

  assign q1_zero = div_q == '0;
  assign div_start = ((state == S_PREP) && job_en && (job_d != '0))
                     || ((state == S_DIV1) && div_stat.done && !q1_zero);
  assign div_dividend = (state == S_PREP) ? job_f : N_W'(NUM);
  assign div_divisor  = (state == S_PREP) ? D_W'(job_d) : div_q[D_W-1:0];
  assign period_val   = (job < JOB_ENV) ? {1'b0, div_q[31:1]} : div_q[31:0];

  psg_div #(.N_W(N_W), .D_W(D_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_q)
  );

  logic        store_en;
  logic [31:0] store_val;

  always_comb begin
    store_en  = 1'b0;
    store_val = '0;
    unique case (state)
      S_PREP: store_en = !(job_en && (job_d != '0));
      S_DIV1: store_en = div_stat.done && q1_zero;
      S_DIV2: begin
        store_en = div_stat.done; store_val = period_val;
      end
      default: store_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      job          <= '0;
      ch           <= '0;
      mute_mask    <= '0;
      for (int i = 0; i < 16; i++) regs[i] <= '0;
      for (int i = 0; i < 3; i++) begin
        tone_half[i] <= '0;
        tone_bal[i]  <= '0;
      end
      tone_phase   <= '0;
      env_period   <= '0;
      env_bal      <= '0;
      env_elapsed  <= '0;
      env_level    <= '0;
      env_seg      <= '0;
      noise_period <= NOISE_RESET;
      noise_bal    <= '0;
      noise_shift  <= 24'd1;
      acc          <= '0;
      rd_hold      <= '0;
      out_valid    <= 1'b0;
      sample       <= '0;
      read_data    <= '0;
    end else begin
      if (cfg_we) begin
        mute_mask <= cfg_data;
      end
      // the final step drives out_valid itself
      if (state != S_FIN && out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (store_en) begin
        unique case (job)
          3'd0:      tone_half[0] <= store_val;
          3'd1:      tone_half[1] <= store_val;
          3'd2:      tone_half[2] <= store_val;
          JOB_ENV:   env_period   <= store_val;
          default:   noise_period <= store_val;
        endcase
        if (job == JOB_NOISE) begin
          state <= S_IDLE;
        end else begin
          job   <= job + 3'd1;
          state <= S_PREP;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            acc     <= '0;
            ch      <= '0;
            job     <= '0;
            rd_hold <= '0;
            unique case (cmd)
              psg_pkg::CMD_WRITE: begin
                regs[reg_index] <= write_data;
                if (reg_index == 4'd13) begin
                  env_seg     <= '0;
                  env_elapsed <= '0;
                  env_bal     <= '0;
                  if (op_wr == psg_pkg::SEG_UP || op_wr == psg_pkg::SEG_ZERO) begin
                    env_level <= '0;
                  end else if (op_wr == psg_pkg::SEG_DOWN || op_wr == psg_pkg::SEG_ONE) begin
                    env_level <= ENV_TOP;
                  end
                end
                state <= S_PREP;
              end
              psg_pkg::CMD_READ: begin
                rd_hold <= regs[reg_index];
                state   <= S_FIN;
              end
              psg_pkg::CMD_TICK: state <= S_T_ADD;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_PREP: begin
          if (!store_en) begin
            state <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (div_stat.done && !q1_zero) begin
            state <= S_DIV2;
          end
        end
        S_DIV2: begin
        end
        S_T_ADD: begin
          if (tone_on) tone_bal[ch] <= alu_res;
          state <= S_T_CMP;
        end
        S_T_CMP: begin
          if (tone_on && alu_ge) begin
            tone_bal[ch]   <= alu_res;
            tone_phase[ch] <= !tone_phase[ch];
          end
          state <= S_T_MIXT;
        end
        S_T_MIXT: begin
          if (tone_on && !muted) acc <= mix_sat;
          state <= S_T_MIXN;
        end
        S_T_MIXN: begin
          if (noise_on) acc <= mix_sat;
          if (ch == 2'd2) begin
            ch    <= '0;
            state <= S_E_ADD;
          end else begin
            ch    <= ch + 2'd1;
            state <= S_T_ADD;
          end
        end
        S_E_ADD: begin
          env_bal <= alu_res;
          state   <= S_E_CMP;
        end
        S_E_CMP: begin
          if (alu_ge) begin
            env_bal <= alu_res;
            if (op_cur == psg_pkg::SEG_UP) begin
              env_level <= env_level + 16'd1;
            end else if (op_cur == psg_pkg::SEG_DOWN && env_level != '0) begin
              env_level <= env_level - 16'd1;
            end
          end
          state <= S_E_ELAP;
        end
        S_E_ELAP: begin
          env_elapsed <= alu_res;
          state       <= S_E_SEG;
        end
        S_E_SEG: begin
          if (alu_ge && op_cur != psg_pkg::SEG_KEEP) begin
            env_seg     <= seg_new;
            env_elapsed <= '0;
            env_bal     <= '0;
            if (op_new == psg_pkg::SEG_UP || op_new == psg_pkg::SEG_ZERO) begin
              env_level <= '0;
            end else if (op_new == psg_pkg::SEG_DOWN || op_new == psg_pkg::SEG_ONE) begin
              env_level <= ENV_TOP;
            end
          end
          state <= (noise_period != '0) ? S_N_ADD : S_FIN;
        end
        S_N_ADD: begin
          noise_bal <= alu_res;
          state     <= S_N_LOOP;
        end
        S_N_LOOP: begin
          if (alu_ge) begin
            noise_bal   <= alu_res;
            noise_shift <= noise_next;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            sample    <= acc;
            read_data <= rd_hold;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // noise register can never fall into the all-zero lock-up
  a_noise_nonzero: assert property (@(posedge clk) disable iff (rst)
    noise_shift != '0) else $error("noise shift register went to zero");

  // every shape repeats or holds before the last segment
  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    env_seg != 2'd3) else $error("envelope segment reached unused slot");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy) else $error("divider restarted while busy");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV1 || state == S_DIV2))
    else $error("divider result with no waiting step");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN)
    else $error("result word raised outside final step");

endmodule

[design/psg_div.sv]
// ----------------------------------------------------------------------------
// psg_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psg_div #(
  parameter int N_W = 40,
  parameter int D_W = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [N_W-1:0]      dividend,
  input  logic [D_W-1:0]      divisor,
  output psg_pkg::div_stat_t  stat,
  output logic [N_W-1:0]      quotient
);

  localparam int CW = $clog2(N_W);

  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [D_W-1:0] dvs;
  logic [D_W-1:0] rem;
  logic [N_W-1:0] quo;
  logic [D_W:0]   rem_sh;
  logic           fits;

  assign rem_sh = {rem, quo[N_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvs  <= divisor;
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        rem <= fits ? D_W'(rem_sh - {1'b0, dvs}) : rem_sh[D_W-1:0];
        quo <= {quo[N_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule
